@@ rtl/core/fwbct_pkg.sv @@
`timescale 1ns / 1ps

package fwbct_pkg;

  // Fixed field widths of the two channels and the configuration register.
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned BLK_W     = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_RESET = 16;

  // Operation codes carried by the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP   = 2'd0,
    FUNC_ALLOCATE = 2'd1,
    FUNC_MARK     = 2'd2,
    FUNC_FLUSH    = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_FLUSH
  } state_t;

endpackage

@@ rtl/core/fifo_writeback_block_cache_tags_unit.sv @@
`timescale 1ns / 1ps
// Sequence: lookup, allocate and mark-dirty are accepted, then scan up to MIN(NUM_ENTRIES,16)
//   slots (the scan stops on the first match) and then load the result.
// Flush is accepted and then visits MIN(NUM_ENTRIES,16) slots, one slot per cycle except
//   while a beat waits on a stalled output. Only one beat is in flight at a time; the
//   single tag comparator visits one slot per cycle.
// Reset: valid/dirty bits, insert pointer and sequencer clear; entries_in_use returns to 16.
module fifo_writeback_block_cache_tags_unit #(
  parameter int unsigned NUM_ENTRIES       = 16,
  parameter int unsigned BLOCK_NUMBER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port: entries_in_use.
  input  logic                              cfg_wr_en,
  input  logic [fwbct_pkg::CFG_W-1:0]       cfg_wr_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fwbct_pkg::FUNC_W-1:0]      in_func,
  input  logic [fwbct_pkg::BLK_W-1:0]       in_block_number,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [fwbct_pkg::SLOT_W-1:0]      out_slot,
  output logic                              out_writeback,
  output logic [fwbct_pkg::BLK_W-1:0]       out_victim_block,
  output logic                              out_last
);

  // Only up to 16 slots are addressable through the slot field.
  localparam int unsigned MAX_SLOTS = (NUM_ENTRIES < 16) ? NUM_ENTRIES : 16;
  localparam int unsigned IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  // Block numbers are masked to the narrower of the port and the parameter.
  localparam int unsigned TAG_W     = (BLOCK_NUMBER_BITS < fwbct_pkg::BLK_W) ?
                                      BLOCK_NUMBER_BITS : fwbct_pkg::BLK_W;
  localparam logic [IDX_W-1:0]            IDX_LAST = IDX_W'(MAX_SLOTS - 1);
  localparam logic [fwbct_pkg::CFG_W-1:0] SIZE_MAX = fwbct_pkg::CFG_W'(MAX_SLOTS);

  fwbct_pkg::state_t state_r, state_nxt;

  // Configuration register.
  logic [fwbct_pkg::CFG_W-1:0] entries_r;

  // Tag store and per-slot status bits.
  logic [TAG_W-1:0]     tag_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid_r, valid_nxt;
  logic [MAX_SLOTS-1:0] dirty_r, dirty_nxt;
  logic [IDX_W-1:0]     ins_ptr_r, ins_ptr_nxt;

  // Per-beat working registers.
  fwbct_pkg::func_t     func_r;
  logic [TAG_W-1:0]     blk_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic                 any_r, any_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic [fwbct_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic                        out_wb_r, out_wb_nxt;
  logic [fwbct_pkg::BLK_W-1:0]  out_victim_r, out_victim_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_accept;
  logic                        out_free;
  logic [fwbct_pkg::CFG_W-1:0] size_eff;
  logic [fwbct_pkg::CFG_W-1:0] ins_ext;
  logic [fwbct_pkg::CFG_W-1:0] alloc_ext;
  logic [fwbct_pkg::CFG_W-1:0] alloc_inc;
  logic [IDX_W-1:0]            alloc_slot;
  logic [IDX_W-1:0]            rd_idx;
  logic [TAG_W-1:0]            tag_rd;
  logic                        cur_hit;
  logic                        cur_vd;
  logic                        higher_vd;
  logic                        flush_emit;
  logic                        flush_step;
  logic                        tag_we;

  assign in_stall  = (state_r != fwbct_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  // The result register can take a new beat when empty or being drained this cycle.
  assign out_free  = !out_valid_r || !out_stall;

  // Effective size: zero counts as one, anything above the slot count is clamped.
  always_comb begin
    if (entries_r == '0) begin
      size_eff = fwbct_pkg::CFG_W'(1);
    end else if (entries_r > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = entries_r;
    end
  end

  // FIFO slot for an allocate miss. A pointer left beyond a shrunk size restarts at 0.
  assign ins_ext    = fwbct_pkg::CFG_W'(ins_ptr_r);
  assign alloc_slot = (ins_ext >= size_eff) ? '0 : ins_ptr_r;
  assign alloc_ext  = fwbct_pkg::CFG_W'(alloc_slot);
  assign alloc_inc  = alloc_ext + fwbct_pkg::CFG_W'(1);

  // Single tag read port: the scan index, or the victim slot when finishing.
  assign rd_idx = (state_r == fwbct_pkg::ST_DONE) ? alloc_slot : idx_r;
  assign tag_rd = tag_r[rd_idx];

  // The shared comparator checks one slot per cycle.
  assign cur_hit = valid_r[idx_r] && (tag_rd == blk_r);
  assign cur_vd  = valid_r[idx_r] && dirty_r[idx_r];

  // Whether any dirty entry lies above the current flush index; decides the last flag.
  always_comb begin
    higher_vd = 1'b0;
    for (int j = 0; j < MAX_SLOTS; j++) begin
      if ((IDX_W'(j) > idx_r) && valid_r[j] && dirty_r[j]) begin
        higher_vd = 1'b1;
      end
    end
  end

  // A flush emits a beat for each dirty entry, or one empty beat when nothing was dirty.
  assign flush_emit = (state_r == fwbct_pkg::ST_FLUSH) &&
                      (cur_vd || ((idx_r == IDX_LAST) && !any_r));
  assign flush_step = (state_r == fwbct_pkg::ST_FLUSH) && (!flush_emit || out_free);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fwbct_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (fwbct_pkg::func_t'(in_func) == fwbct_pkg::FUNC_FLUSH) begin
            state_nxt = fwbct_pkg::ST_FLUSH;
          end else begin
            state_nxt = fwbct_pkg::ST_SCAN;
          end
        end
      end
      fwbct_pkg::ST_SCAN: begin
        if (cur_hit || (idx_r == IDX_LAST)) begin
          state_nxt = fwbct_pkg::ST_DONE;
        end
      end
      fwbct_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = fwbct_pkg::ST_IDLE;
        end
      end
      fwbct_pkg::ST_FLUSH: begin
        if (flush_step && (idx_r == IDX_LAST)) begin
          state_nxt = fwbct_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fwbct_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result values.
  always_comb begin
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    any_nxt        = any_r;
    valid_nxt      = valid_r;
    dirty_nxt      = dirty_r;
    ins_ptr_nxt    = ins_ptr_r;
    tag_we         = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_wb_nxt     = out_wb_r;
    out_victim_nxt = out_victim_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      fwbct_pkg::ST_IDLE: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        any_nxt   = 1'b0;
      end
      fwbct_pkg::ST_SCAN: begin
        // On a match the index stays put and names the resident slot.
        if (cur_hit) begin
          found_nxt = 1'b1;
        end else if (idx_r != IDX_LAST) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      fwbct_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_hit_nxt    = found_r;
          out_slot_nxt   = found_r ? fwbct_pkg::SLOT_W'(idx_r) : '0;
          out_wb_nxt     = 1'b0;
          out_victim_nxt = '0;
          if (func_r == fwbct_pkg::FUNC_MARK && found_r) begin
            dirty_nxt[idx_r] = 1'b1;
          end
          if (func_r == fwbct_pkg::FUNC_ALLOCATE && !found_r) begin
            // Evict the FIFO slot; a valid dirty occupant goes out for write-back.
            out_slot_nxt = fwbct_pkg::SLOT_W'(alloc_slot);
            if (valid_r[alloc_slot] && dirty_r[alloc_slot]) begin
              out_wb_nxt     = 1'b1;
              out_victim_nxt = fwbct_pkg::BLK_W'(tag_rd);
            end
            tag_we                = 1'b1;
            valid_nxt[alloc_slot] = 1'b1;
            dirty_nxt[alloc_slot] = 1'b0;
            ins_ptr_nxt = (alloc_inc >= size_eff) ? '0 : IDX_W'(alloc_inc);
          end
        end
      end
      fwbct_pkg::ST_FLUSH: begin
        if (flush_emit && out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          if (cur_vd) begin
            out_slot_nxt   = fwbct_pkg::SLOT_W'(idx_r);
            out_wb_nxt     = 1'b1;
            out_victim_nxt = fwbct_pkg::BLK_W'(tag_rd);
            out_last_nxt   = !higher_vd;
          end else begin
            out_slot_nxt   = '0;
            out_wb_nxt     = 1'b0;
            out_victim_nxt = '0;
            out_last_nxt   = 1'b1;
          end
        end
        if (flush_step) begin
          any_nxt = any_r || cur_vd;
          if (idx_r == IDX_LAST) begin
            valid_nxt   = '0;
            dirty_nxt   = '0;
            ins_ptr_nxt = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fwbct_pkg::ST_IDLE;
      entries_r   <= fwbct_pkg::CFG_W'(fwbct_pkg::CFG_RESET);
      valid_r     <= '0;
      dirty_r     <= '0;
      ins_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        entries_r <= cfg_wr_data;
      end
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      ins_ptr_r   <= ins_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= fwbct_pkg::func_t'(in_func);
      blk_r  <= in_block_number[TAG_W-1:0];
    end
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    any_r        <= any_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_wb_r     <= out_wb_nxt;
    out_victim_r <= out_victim_nxt;
    out_last_r   <= out_last_nxt;
    if (tag_we) begin
      tag_r[alloc_slot] <= blk_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_slot         = out_slot_r;
  assign out_writeback    = out_wb_r;
  assign out_victim_block = out_victim_r;
  assign out_last         = out_last_r;

  // A resident block never causes a write-back.
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> !out_wb_r)
    else $error("hit beat carries a write-back");

  // After a flush completes the store is empty and the pointer is back at slot 0.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fwbct_pkg::ST_FLUSH) && (state_nxt == fwbct_pkg::ST_IDLE)
    |=> (valid_r == '0) && (dirty_r == '0) && (ins_ptr_r == '0))
    else $error("flush left entries behind");

  // A scan or flush only starts from an accepted input beat.
  a_start_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fwbct_pkg::ST_IDLE) && (state_nxt != fwbct_pkg::ST_IDLE)
    |-> in_valid && !in_stall)
    else $error("sequencer started without an input beat");

  // Every dirty entry is also valid.
  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (dirty_r & ~valid_r) == '0)
    else $error("dirty bit set on an invalid slot");

endmodule
